[rtl/core/sha256_message_hasher_assert.svh]
// Assertion macros for the SHA-256 message hasher checker.
// Included by the checker file only.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SHA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[rtl/core/sha_pkg.sv]
// Package for the SHA-256 message hasher: types, constants and round functions.
// Used by all modules of the hasher.
package sha_pkg;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RC [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction
endpackage

[rtl/core/sha_if.sv]
// Valid/ready channel interfaces for the SHA-256 hasher.
// Depends on sha_pkg for the payload types.
interface sha_in_if (input logic clk);
  import sha_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sha_out_if (input logic clk);
  import sha_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/core/sha_front.sv]
// Front end of the SHA-256 hasher: drops empty items and queues the rest.
// Depends on sha_pkg and sha_if.
module sha_front (
  input  logic                clk,
  input  logic                rst,
  sha_in_if.sink              in_ch,
  output sha_pkg::in_item_t   q_data,
  output logic                q_valid,
  input  logic                q_pop
);
  import sha_pkg::*;
  localparam int unsigned AW = $clog2(QueueDepth);

  in_item_t       mem [QueueDepth];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           push;
  logic           keep;
  logic           pop;

  assign in_ch.ready = (count != (AW+1)'(QueueDepth));
  // Items with neither a byte nor an end mark change nothing and are dropped.
  assign keep = in_ch.data.has_byte | in_ch.data.end_of_message;
  assign push = in_ch.valid & in_ch.ready & keep;
  assign pop  = q_pop & q_valid;
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_ch.data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

[rtl/core/sha_back.sv]
// Back end of the SHA-256 hasher: byte packing, padding, 64-round compression
// and digest output. Depends on sha_pkg and sha_if.
module sha_back (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::in_item_t   q_data,
  input  logic                q_valid,
  output logic                q_pop,
  sha_out_if.source           out_ch
);
  import sha_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t       state;
  logic [31:0]  hash [8];
  logic [31:0]  blk [16];
  logic [31:0]  ring [16];
  logic [31:0]  wv [8];
  logic [63:0]  bit_count;
  logic [63:0]  len;
  logic [5:0]   fill;
  logic [5:0]   rnd;
  logic [2:0]   oidx;
  logic         finishing;
  logic         pad_done;
  logic         len_ok;
  logic         last_len_blk;

  logic [7:0]   pad_byte;
  logic [7:0]   put_val;
  logic         put_en;
  logic [31:0]  w;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [1:0]   bsel;

  assign q_pop = (state == S_IDLE) && q_valid;

  // Padding byte stream: 0x80 first, then zeros, and the length in bytes 56
  // to 63 of the block that holds it. When the marker lands at byte 56 or
  // later, the rest of that block is zero and the length goes in one more.
  always_comb begin
    pad_byte = 8'h00;
    if (!pad_done) begin
      pad_byte = PadByte;
    end else if (len_ok && fill >= 6'd56) begin
      pad_byte = len[8*(6'd63 - fill) +: 8];
    end
  end

  always_comb begin
    put_en  = 1'b0;
    put_val = pad_byte;
    if (state == S_IDLE && q_valid && q_data.has_byte) begin
      put_en  = 1'b1;
      put_val = q_data.data_byte;
    end else if (state == S_PAD) begin
      put_en = 1'b1;
    end
  end

  assign bsel = 2'd3 - fill[1:0];

  always_comb begin
    if (rnd < 6'd16) begin
      w = blk[rnd[3:0]];
    end else begin
      w = ssig1(ring[4'(rnd - 6'd2)]) + ring[4'(rnd - 6'd7)]
        + ssig0(ring[4'(rnd - 6'd15)]) + ring[rnd[3:0]];
    end
    t1 = wv[7] + bsig1(wv[4]) + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + RC[rnd] + w;
    t2 = bsig0(wv[0]) + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data.digest_word = hash[oidx];
  assign out_ch.data.word_index  = oidx;
  assign out_ch.data.last_word   = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (put_en) begin
      blk[fill[5:2]][8*bsel +: 8] <= put_val;
    end
    if (state == S_LOAD) begin
      for (int i = 0; i < 8; i++) wv[i] <= hash[i];
    end
    if (state == S_ROUND) begin
      ring[rnd[3:0]] <= w;
      wv[7] <= wv[6];
      wv[6] <= wv[5];
      wv[5] <= wv[4];
      wv[4] <= wv[3] + t1;
      wv[3] <= wv[2];
      wv[2] <= wv[1];
      wv[1] <= wv[0];
      wv[0] <= t1 + t2;
    end
    if (rst) begin
      state     <= S_IDLE;
      for (int i = 0; i < 8; i++) hash[i] <= IV[i];
      bit_count <= '0;
      fill      <= '0;
      rnd       <= '0;
      oidx      <= '0;
      finishing <= 1'b0;
      pad_done  <= 1'b0;
      len_ok    <= 1'b0;
      last_len_blk <= 1'b0;
      len       <= '0;
    end else begin
      if (put_en) fill <= fill + 6'd1;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            finishing <= q_data.end_of_message;
            pad_done  <= 1'b0;
            len_ok    <= 1'b0;
            last_len_blk <= 1'b0;
            len       <= bit_count + (q_data.has_byte ? 64'd8 : 64'd0);
            if (q_data.has_byte) bit_count <= bit_count + 64'd8;
            if (q_data.has_byte && fill == 6'd63) begin
              state <= S_LOAD;
            end else if (q_data.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_done <= 1'b1;
          if (!pad_done && fill < 6'd56) len_ok <= 1'b1;
          if (fill == 6'd63) begin
            // A block closing with the length is the last one; otherwise
            // the length goes in the next block.
            if (len_ok) begin
              last_len_blk <= 1'b1;
            end else begin
              len_ok <= 1'b1;
            end
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) hash[i] <= hash[i] + wv[i];
          if (!finishing) begin
            state <= S_IDLE;
          end else if (last_len_blk) begin
            oidx  <= '0;
            state <= S_OUT;
          end else begin
            state <= S_PAD;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              for (int i = 0; i < 8; i++) hash[i] <= IV[i];
              bit_count <= '0;
              fill      <= '0;
              finishing <= 1'b0;
              state     <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/sha256_message_hasher.sv]
// Top level of the SHA-256 message hasher.
// Depends on sha_pkg, sha_if, sha_front and sha_back.
//
//   channel   direction  word contents
//   in_ch     sink       has_byte, data_byte, end_of_message
//   out_ch    source     digest_word, word_index, last_word
//
// The back end takes a byte only while idle; a full block then goes through
// load, 64 rounds of the single round unit and the hash update.
// Message end adds the padding bytes plus one or two blocks, then
// eight output words. Reset is synchronous and needs no clearing pass.
// A four-word queue lets input continue while the back end compresses.
module sha256_message_hasher (
  input  logic   clk,
  input  logic   rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  import sha_pkg::*;

  in_item_t q_data;
  logic     q_valid;
  logic     q_pop;

  sha_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  sha_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_data  (q_data),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule

[rtl/core/sha_checker.sv]
// Port-level checker for the SHA-256 hasher, bound to the top level.
// Depends on sha256_message_hasher_assert.svh.
`include "sha256_message_hasher_assert.svh"
module sha_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  word_index,
  input logic        last_word
);
  `SHA_ASSERT_IMP(a_last_idx, out_valid, last_word == (word_index == 3'd7), "last_word mismatch")
  `SHA_ASSERT_NXT(a_idx_step, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 3'd1, "digest words not contiguous")
  `SHA_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(word_index), "word dropped while stalled")
endmodule

bind sha256_message_hasher sha_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .word_index (out_ch.data.word_index),
  .last_word  (out_ch.data.last_word)
);

[sim/sha256_message_hasher_tb.sv]
`timescale 1ns / 1ps
// Testbench for the SHA-256 message hasher: drives bytes and message ends,
// predicts digests with its own SHA-256 model and checks every output word.
// Depends on sha_pkg, sha_if and the hasher RTL.
module sha256_message_hasher_tb;
  import sha_pkg::*;

  logic clk;
  logic rst;

  sha_in_if  in_ch (.clk(clk));
  sha_out_if out_ch (.clk(clk));

  sha256_message_hasher i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // Predictor state
  logic [31:0] hash_state [8];
  logic [31:0] msg_block [16];
  logic [63:0] msg_bits;
  int unsigned block_pos;

  in_item_t  pending_words[$];
  out_item_t expected_digest[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit hold_send;
  bit failed;

  function automatic logic [31:0] rr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++) w[t] = msg_block[t];
    for (int t = 16; t < 64; t++) begin
      w[t] = (rr(w[t-2], 17) ^ rr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
           + (rr(w[t-15], 7) ^ rr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rr(e, 6) ^ rr(e, 11) ^ rr(e, 25)) + ((e & f) ^ (~e & g)) + RC[t] + w[t];
      t2 = (rr(a, 2) ^ rr(a, 13) ^ rr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endtask

  task automatic absorb_byte(logic [7:0] bt);
    msg_block[block_pos / 4][(3 - block_pos % 4) * 8 +: 8] = bt;
    block_pos++;
    if (block_pos == 64) begin
      compress_block();
      block_pos = 0;
    end
  endtask

  task automatic predict_word(in_item_t it);
    logic [63:0] len;
    if (it.has_byte) begin
      absorb_byte(it.data_byte);
      msg_bits += 64'd8;
    end
    if (it.end_of_message) begin
      len = msg_bits;
      absorb_byte(PadByte);
      while (block_pos != 56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[56 - 8 * i +: 8]);
      for (int i = 0; i < 8; i++) begin
        expected_digest.push_back('{digest_word: hash_state[i], word_index: 3'(i),
                                    last_word: (i == 7)});
      end
      for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
      msg_bits = '0;
      block_pos = 0;
    end
  endtask

  function automatic in_item_t mk(bit hb, logic [7:0] db, bit eom);
    in_item_t it;
    it.has_byte = hb;
    it.data_byte = db;
    it.end_of_message = eom;
    return it;
  endfunction

  task automatic queue_message(int unsigned nbytes, bit empty_end);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 9) == 0) pending_words.push_back(mk(0, 8'($urandom), 0));
      pending_words.push_back(mk(1, 8'($urandom), (i == nbytes - 1) && !empty_end));
    end
    if (empty_end || nbytes == 0) pending_words.push_back(mk(0, 8'($urandom), 1));
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_words.size() > 0 && !hold_send &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data <= pending_words.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Predict on acceptance and check the output channel.
  always @(posedge clk) begin
    out_item_t got, exp_w;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_word(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_digest.size() == 0) begin
          $display("%0t: unexpected digest word %h", $realtime, got);
          failed = 1;
        end else begin
          exp_w = expected_digest.pop_front();
          if (got.digest_word !== exp_w.digest_word || got.word_index !== exp_w.word_index ||
              got.last_word !== exp_w.last_word) begin
            $display("%0t: mismatch expected word %h idx %0d last %b, got %h idx %0d last %b",
                     $realtime, exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                     got.digest_word, got.word_index, got.last_word);
            failed = 1;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic drain();
    while (pending_words.size() > 0 || in_ch.valid || expected_digest.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    int unsigned phase_idle [4] = '{0, 86, 0, 8};
    int unsigned phase_stall [4] = '{0, 0, 86, 8};
    for (int i = 0; i < 8; i++) hash_state[i] = IV[i];
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    msg_bits = '0;
    block_pos = 0;
    failed = 0;
    hold_send = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1;
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed: empty message, "abc", extremes, idle words.
    pending_words.push_back(mk(0, 8'hff, 0));
    pending_words.push_back(mk(0, 8'h00, 1));
    pending_words.push_back(mk(1, 8'h61, 0));
    pending_words.push_back(mk(1, 8'h62, 0));
    pending_words.push_back(mk(1, 8'h63, 1));
    pending_words.push_back(mk(1, 8'h00, 1));
    pending_words.push_back(mk(1, 8'hff, 0));
    pending_words.push_back(mk(0, 8'h5a, 0));
    pending_words.push_back(mk(0, 8'ha5, 1));
    drain();

    // Once every expected word is out, the sender holds back before the next phase.
    hold_send = 1;
    repeat (20) @(posedge clk);
    hold_send = 0;

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      case (p)
        0: begin
          queue_message(55, 0);
          queue_message(56, 0);
        end
        default: begin
          for (int m = 0; m < 3; m++) queue_message($urandom_range(0, 10), $urandom_range(0, 1));
          queue_message($urandom_range(40, 70), $urandom_range(0, 1));
        end
      endcase
      drain();
    end
    recv_stall_pct = 0;
    send_idle_pct = 0;
    repeat (200) @(posedge clk);
    if (!failed) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end
endmodule
